// File: hw/rtl/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES_DEF     = 65536;
    localparam int ALIGN_BYTES_DEF    = 8;
    localparam int HEADER_BYTES_DEF   = 16;
    localparam int MIN_TAIL_BYTES_DEF = 16;

    localparam int LIMIT_W = 17;
    localparam int SIZE_W  = 17;
    localparam int ADDR_W  = 16;
    localparam int STAT_W  = 2;
    // A rounded request can carry one bit more than the request itself.
    localparam int REQ_W   = SIZE_W + 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] STAT_ALLOC = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FREED = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] payload_addr;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [STAT_W-1:0] status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_RND2,
        ST_A_LOOK,
        ST_A_SPLIT,
        ST_A_MARK,
        ST_F_LOOK,
        ST_F_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              load_limit;
        logic              init_wr;
        logic              accept;
        logic              rnd1;
        logic              rnd2;
        logic              start_walk;
        logic              step;
        logic              a_split;
        logic              a_mark;
        logic              f_hit;
        logic              f_write;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic paddr_low;
        logic fit;
        logic split;
        logic last;
        logic at_target;
        logic overshoot;
        logic cur_used;
    } sts_t;

    // Block headers sit on multiples of the largest power of two that divides
    // both the alignment and the header size, so that is the store's grain.
    function automatic int ffha_grain_shift(input int align, input int header);
        int v;
        int sh;
        v  = align | header;
        sh = 0;
        for (int i = 6; i >= 0; i--) begin
            if (v[i]) begin
                sh = i;
            end
        end
        return sh;
    endfunction

endpackage

// File: hw/rtl/ffha_ctrl.sv
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (cfg_valid) begin
                    state_next = ST_INIT;
                end else if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.is_free) begin
                    state_next = sts.paddr_low ? ST_DONE : ST_F_LOOK;
                end else begin
                    state_next = sts.size_zero ? ST_DONE : ST_RND2;
                end
            end
            ST_RND2: begin
                state_next = ST_A_LOOK;
            end
            ST_A_LOOK: begin
                priority if (sts.fit && sts.split) begin
                    state_next = ST_A_SPLIT;
                end else if (sts.fit) begin
                    state_next = ST_A_MARK;
                end else if (sts.last) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_A_LOOK;
                end
            end
            ST_A_SPLIT: begin
                state_next = ST_A_MARK;
            end
            ST_A_MARK: begin
                state_next = ST_DONE;
            end
            ST_F_LOOK: begin
                priority if (sts.at_target) begin
                    state_next = sts.cur_used ? ST_F_NEXT : ST_DONE;
                end else if (sts.overshoot) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_F_LOOK;
                end
            end
            ST_F_NEXT: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.init_wr = 1'b1;
            end
            ST_IDLE: begin
                cfg_ready      = 1'b1;
                s_ready        = !cfg_valid;
                cmd.load_limit = cfg_valid;
                cmd.accept     = !cfg_valid && s_valid;
            end
            ST_CHECK: begin
                if (sts.is_free) begin
                    if (sts.paddr_low) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_FAIL;
                    end else begin
                        cmd.start_walk = 1'b1;
                    end
                end else begin
                    if (sts.size_zero) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_FAIL;
                    end else begin
                        cmd.rnd1 = 1'b1;
                    end
                end
            end
            ST_RND2: begin
                cmd.rnd2       = 1'b1;
                cmd.start_walk = 1'b1;
            end
            ST_A_LOOK: begin
                if (!sts.fit) begin
                    if (sts.last) begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_FAIL;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_A_SPLIT: begin
                cmd.a_split = 1'b1;
            end
            ST_A_MARK: begin
                cmd.a_mark   = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = STAT_ALLOC;
            end
            ST_F_LOOK: begin
                priority if (sts.at_target) begin
                    if (sts.cur_used) begin
                        cmd.f_hit = 1'b1;
                    end else begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = STAT_FAIL;
                    end
                end else if (sts.overshoot) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = STAT_FAIL;
                end else begin
                    cmd.step = 1'b1;
                end
            end
            ST_F_NEXT: begin
                cmd.f_write  = 1'b1;
                cmd.res_set  = 1'b1;
                cmd.res_code = STAT_FREED;
            end
            ST_DONE: begin
                cmd.load_out = out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: hw/rtl/ffha_dpath.sv
module ffha_dpath
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES     = HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES    = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
    parameter int MIN_TAIL_BYTES = MIN_TAIL_BYTES_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [LIMIT_W-1:0] cfg_wdata,
    input  in_item_t           s_data,
    output out_item_t          m_data,
    input  cmd_t               cmd,
    output sts_t               sts
);

    localparam int OFF_W  = $clog2(HEAP_BYTES);
    localparam int SZ_W   = OFF_W;
    localparam int GSH    = ffha_grain_shift(ALIGN_BYTES, HEADER_BYTES);
    localparam int GRAIN  = 1 << GSH;
    localparam int DEPTH  = (HEAP_BYTES + GRAIN - 1) / GRAIN;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CW     = ((OFF_W > REQ_W) ? OFF_W : REQ_W) + 2;
    // Rounding uses a reciprocal that is exact for every request width value.
    localparam int RCP_S  = REQ_W + $clog2(ALIGN_BYTES);
    localparam int RCP_W  = RCP_S + 1;
    localparam int PROD_W = REQ_W + RCP_W;
    localparam int Q_W    = PROD_W - RCP_S;
    localparam logic [RCP_W-1:0] RCP_M =
        RCP_W'(((64'd1 << RCP_S) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES));
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] SPLIT_C = CW'(HEADER_BYTES + MIN_TAIL_BYTES);
    localparam logic [CW-1:0] HEAP_C  = CW'(HEAP_BYTES);

    typedef struct packed {
        logic [SZ_W-1:0]  size;
        logic             used;
        logic [IDX_W-1:0] link;
    } hdr_t;

    hdr_t                hdr_mem [DEPTH];
    hdr_t                rd_hdr_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    in_item_t            item_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic [IDX_W-1:0]    prev_reg;
    logic [IDX_W-1:0]    sel_reg;
    logic [IDX_W-1:0]    link_save_reg;
    logic [SZ_W-1:0]     prev_size_reg;
    logic                prev_used_reg;
    logic                has_prev_reg;
    logic                have_nx_reg;
    logic [CW-1:0]       acc_reg;
    logic [STAT_W-1:0]   res_stat_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    out_item_t           out_reg;

    logic [REQ_W-1:0]    x_sum;
    logic [CW-1:0]       cur_off;
    logic [CW-1:0]       link_off;
    logic [CW-1:0]       target;
    logic [CW-1:0]       hsize;
    logic [CW-1:0]       req_ext;
    logic [CW-1:0]       left;
    logic [CW-1:0]       sp_off;
    logic [IDX_W-1:0]    sp_idx;
    logic                fit;
    logic                split_ok;
    logic                prev_free;
    logic                nx_free;
    logic [CW-1:0]       lim_ext;
    logic [CW-1:0]       cap_sel;
    logic [CW-1:0]       cap_fix;
    logic [CW-1:0]       acc_hit;
    logic [CW-1:0]       merged;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    hdr_t                wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_idx;

    assign x_sum    = REQ_W'(item_reg.request_size) + REQ_W'(ALIGN_BYTES - 1);
    assign cur_off  = CW'(cur_reg) << GSH;
    assign link_off = CW'(rd_hdr_reg.link) << GSH;
    assign target   = CW'(item_reg.payload_addr) - HDR_C;
    assign hsize    = CW'(rd_hdr_reg.size);
    assign req_ext  = CW'(req_reg);
    assign left     = hsize - req_ext;
    assign sp_off   = cur_off + HDR_C + req_ext;
    assign sp_idx   = IDX_W'(sp_off >> GSH);
    assign fit      = !rd_hdr_reg.used && (hsize >= req_ext);
    assign split_ok = left >= SPLIT_C;
    assign prev_free = has_prev_reg && !prev_used_reg;
    assign nx_free   = have_nx_reg && !rd_hdr_reg.used;

    // A limit of zero or beyond the heap selects the whole heap.
    assign lim_ext = CW'(limit_reg);
    assign cap_sel = (lim_ext != '0 && lim_ext < HEAP_C) ? lim_ext : HEAP_C;
    assign cap_fix = (cap_sel < HDR_C) ? HDR_C : cap_sel;

    assign acc_hit = hsize + (prev_free ? (CW'(prev_size_reg) + HDR_C) : '0);
    assign merged  = acc_reg + (nx_free ? (hsize + HDR_C) : '0);

    always_comb begin
        sts.is_free   = item_reg.mode == MODE_FREE;
        sts.size_zero = item_reg.request_size == '0;
        sts.paddr_low = CW'(item_reg.payload_addr) < HDR_C;
        sts.fit       = fit;
        sts.split     = split_ok;
        sts.last      = rd_hdr_reg.link == '0;
        sts.at_target = cur_off == target;
        sts.overshoot = (rd_hdr_reg.link == '0) || (link_off > target);
        sts.cur_used  = rd_hdr_reg.used;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = '0;
        wr_data = '0;
        priority if (cmd.init_wr) begin
            wr_en        = 1'b1;
            wr_data.size = SZ_W'(cap_fix - HDR_C);
        end else if (cmd.a_split) begin
            wr_en        = 1'b1;
            wr_idx       = sp_idx;
            wr_data.size = SZ_W'(left - HDR_C);
            wr_data.link = rd_hdr_reg.link;
        end else if (cmd.a_mark) begin
            wr_en        = 1'b1;
            wr_idx       = cur_reg;
            wr_data.used = 1'b1;
            wr_data.size = split_ok ? SZ_W'(req_reg) : rd_hdr_reg.size;
            wr_data.link = split_ok ? sp_idx : rd_hdr_reg.link;
        end else if (cmd.f_write) begin
            wr_en        = 1'b1;
            wr_idx       = sel_reg;
            wr_data.size = SZ_W'(merged);
            wr_data.link = nx_free ? rd_hdr_reg.link : link_save_reg;
        end else begin
            wr_en        = 1'b0;
        end
    end

    assign rd_en  = cmd.start_walk || cmd.step || (cmd.f_hit && rd_hdr_reg.link != '0);
    assign rd_idx = cmd.start_walk ? '0 : rd_hdr_reg.link;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_hdr_reg <= hdr_mem[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (cmd.load_limit) begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.rnd1) begin
            prod_reg <= PROD_W'(x_sum) * PROD_W'(RCP_M);
        end
        if (cmd.rnd2) begin
            req_reg <= REQ_W'(prod_reg[PROD_W-1:RCP_S] * Q_W'(ALIGN_BYTES));
        end
        if (cmd.start_walk) begin
            cur_reg      <= '0;
            has_prev_reg <= 1'b0;
        end else if (cmd.step) begin
            cur_reg       <= rd_hdr_reg.link;
            prev_reg      <= cur_reg;
            prev_size_reg <= rd_hdr_reg.size;
            prev_used_reg <= rd_hdr_reg.used;
            has_prev_reg  <= 1'b1;
        end
        if (cmd.f_hit) begin
            acc_reg       <= acc_hit;
            sel_reg       <= prev_free ? prev_reg : cur_reg;
            link_save_reg <= rd_hdr_reg.link;
            have_nx_reg   <= rd_hdr_reg.link != '0;
        end
        if (cmd.res_set) begin
            res_stat_reg <= cmd.res_code;
            res_addr_reg <= (cmd.res_code == STAT_ALLOC) ?
                            ADDR_W'(cur_off + HDR_C) : '0;
        end
        if (cmd.load_out) begin
            out_reg.result_addr <= res_addr_reg;
            out_reg.status      <= res_stat_reg;
        end
    end

    assign m_data = out_reg;

endmodule

// File: hw/rtl/first_fit_heap_allocator.sv
// A request walks its block headers at one per cycle. An allocate checks the size, rounds it,
// walks to the first fit, splits the block when the tail is large enough and marks it used;
// a free walks to its header and merges it with free neighbors; a failed check is refused.
// One request is in work at a time; the next is taken the cycle after the result is
// loaded, and loading waits while an earlier result is still held off by m_ready.
// Reset is synchronous, active low; the cycle after it, and after a heap_limit write, builds the heap.
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_BYTES     = HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES    = ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES   = HEADER_BYTES_DEF,
    parameter int MIN_TAIL_BYTES = MIN_TAIL_BYTES_DEF
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    ffha_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ffha_dpath #(
        .HEAP_BYTES     (HEAP_BYTES),
        .ALIGN_BYTES    (ALIGN_BYTES),
        .HEADER_BYTES   (HEADER_BYTES),
        .MIN_TAIL_BYTES (MIN_TAIL_BYTES)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: dv/testbench.sv
module testbench;
    import ffha_pkg::*;

    localparam int unsigned HEAP        = HEAP_BYTES_DEF;
    localparam int unsigned ALIGN       = ALIGN_BYTES_DEF;
    localparam int unsigned HDR         = HEADER_BYTES_DEF;
    localparam int unsigned MIN_TAIL    = MIN_TAIL_BYTES_DEF;
    localparam int unsigned LIVE_CAP    = 48;
    localparam int unsigned PER_PHASE   = 234;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE      = 12;
    localparam int unsigned CYCLE_LIMIT = 1500000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_item_t           s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_item_t          m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_wdata = '0;

    // Heap image kept by the predictor, indexed by header byte offset.
    logic [SIZE_W-1:0] blk_bytes [HEAP];
    bit                blk_used  [HEAP];
    logic [ADDR_W-1:0] blk_next  [HEAP];
    int unsigned       heap_limit_q;

    out_item_t         pending_replies[$];
    logic [ADDR_W-1:0] live_payloads[$];
    logic [ADDR_W-1:0] last_freed = 16'd16;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned n_requests = 0;
    int unsigned n_granted = 0;
    int unsigned n_freed = 0;
    int unsigned n_refused = 0;
    int unsigned n_checked = 0;
    int unsigned n_limit_writes = 0;
    out_item_t   want;
    out_item_t   reply;

    first_fit_heap_allocator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void rebuild_heap();
        int unsigned cap;
        cap = HEAP;
        if (heap_limit_q != 0 && heap_limit_q < HEAP) begin
            cap = heap_limit_q;
        end
        if (cap < HDR) begin
            cap = HDR;
        end
        blk_bytes[0] = SIZE_W'(cap - HDR);
        blk_used[0]  = 1'b0;
        blk_next[0]  = '0;
    endfunction

    function automatic out_item_t predict_alloc(int unsigned size);
        out_item_t   r;
        int unsigned req;
        int unsigned cur;
        int unsigned left;
        int unsigned sp;
        r.result_addr = '0;
        r.status      = STAT_FAIL;
        if (size == 0) begin
            return r;
        end
        req = ((size + ALIGN - 1) / ALIGN) * ALIGN;
        cur = 0;
        forever begin
            if (!blk_used[cur] && blk_bytes[cur] >= req) begin
                left = 32'(blk_bytes[cur]) - req;
                // A split needs room for a header plus a minimal tail payload.
                if (left >= HDR + MIN_TAIL) begin
                    sp = cur + HDR + req;
                    blk_bytes[sp] = SIZE_W'(left - HDR);
                    blk_used[sp]  = 1'b0;
                    blk_next[sp]  = blk_next[cur];
                    blk_bytes[cur] = SIZE_W'(req);
                    blk_next[cur]  = ADDR_W'(sp);
                end
                blk_used[cur] = 1'b1;
                r.result_addr = ADDR_W'(cur + HDR);
                r.status      = STAT_ALLOC;
                return r;
            end
            if (blk_next[cur] == 0) begin
                return r;
            end
            cur = 32'(blk_next[cur]);
        end
    endfunction

    function automatic out_item_t predict_free(int unsigned paddr);
        out_item_t   r;
        int unsigned target;
        int unsigned cur;
        int unsigned prev;
        int unsigned nx;
        bit          has_prev;
        r.result_addr = '0;
        r.status      = STAT_FAIL;
        has_prev      = 1'b0;
        prev          = 0;
        if (paddr < HDR) begin
            return r;
        end
        target = paddr - HDR;
        cur    = 0;
        while (cur != target) begin
            if (blk_next[cur] == 0 || blk_next[cur] > target) begin
                return r;
            end
            prev     = cur;
            has_prev = 1'b1;
            cur      = 32'(blk_next[cur]);
        end
        if (!blk_used[cur]) begin
            return r;
        end
        blk_used[cur] = 1'b0;
        if (has_prev && !blk_used[prev]) begin
            blk_bytes[prev] = blk_bytes[prev] + blk_bytes[cur] + SIZE_W'(HDR);
            blk_next[prev]  = blk_next[cur];
            cur = prev;
        end
        nx = 32'(blk_next[cur]);
        if (nx != 0 && !blk_used[nx]) begin
            blk_bytes[cur] = blk_bytes[cur] + blk_bytes[nx] + SIZE_W'(HDR);
            blk_next[cur]  = blk_next[nx];
        end
        r.status = STAT_FREED;
        return r;
    endfunction

    function automatic out_item_t predict_request(in_item_t item);
        if (item.mode == MODE_FREE) begin
            return predict_free(32'(item.payload_addr));
        end
        return predict_alloc(32'(item.request_size));
    endfunction

    // Results are compared before the new request is predicted; with one
    // request in flight the two never touch the same queue entry.
    always @(posedge aclk) begin
        if (!aresetn) begin
            heap_limit_q = 0;
            rebuild_heap();
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (pending_replies.size() == 0) begin
                    $error("reply with nothing outstanding: result_addr %0d status %0d",
                           m_data.result_addr, m_data.status);
                    mismatches++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_data.result_addr !== want.result_addr) begin
                        $error("result_addr: expected %0d, got %0d",
                               want.result_addr, m_data.result_addr);
                        mismatches++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_data.status);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                heap_limit_q = 32'(cfg_wdata);
                rebuild_heap();
                n_limit_writes++;
            end
            if (s_valid && s_ready) begin
                reply = predict_request(s_data);
                pending_replies.push_back(reply);
                n_requests++;
                if (reply.status == STAT_ALLOC) begin
                    n_granted++;
                    live_payloads.push_back(reply.result_addr);
                end else if (reply.status == STAT_FREED) begin
                    n_freed++;
                end else begin
                    n_refused++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    // Called at a clock edge. Valid stays high into the next request unless
    // the sender decides to go idle after this one.
    task automatic send_request(input in_item_t item);
        s_data  <= item;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic alloc_bytes(input int unsigned size);
        in_item_t item;
        item.mode         = MODE_ALLOC;
        item.request_size = SIZE_W'(size);
        item.payload_addr = ADDR_W'($urandom);
        send_request(item);
    endtask

    task automatic free_payload(input int unsigned addr);
        in_item_t item;
        item.mode         = MODE_FREE;
        item.request_size = SIZE_W'($urandom);
        item.payload_addr = ADDR_W'(addr);
        send_request(item);
    endtask

    // The first edge lets the checker record a request accepted just before.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_heap_limit(input logic [LIMIT_W-1:0] lim);
        wait_quiet();
        cfg_wdata <= lim;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        live_payloads.delete();
    endtask

    function automatic in_item_t next_random_request();
        in_item_t    item;
        int unsigned pick;
        int unsigned idx;
        int unsigned free_odds;
        item.mode         = MODE_ALLOC;
        item.request_size = SIZE_W'($urandom);
        item.payload_addr = ADDR_W'($urandom);
        free_odds = (live_payloads.size() >= LIVE_CAP) ? 75 : 40;
        pick = $urandom_range(99);
        if (pick < 4) begin
            // Noise: an offset that is almost never a live block.
            item.mode = MODE_FREE;
        end else if (live_payloads.size() != 0 && pick < free_odds) begin
            item.mode = MODE_FREE;
            pick = $urandom_range(99);
            if (pick < 85) begin
                idx = $urandom_range(live_payloads.size() - 1);
                item.payload_addr = live_payloads[idx];
                live_payloads.delete(idx);
                last_freed = item.payload_addr;
            end else if (pick < 95) begin
                item.payload_addr = last_freed;
            end
        end else begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                item.request_size = SIZE_W'($urandom_range(256, 1));
            end else if (pick < 85) begin
                item.request_size = SIZE_W'($urandom_range(4096, 257));
            end else if (pick < 90) begin
                item.request_size = '0;
            end else if (pick < 95) begin
                item.request_size = SIZE_W'($urandom_range(65536, 4097));
            end
        end
        return item;
    endfunction

    task automatic test_edge_requests();
        idle_pct  = 0;
        stall_pct = 0;
        alloc_bytes(0);
        alloc_bytes(65536);
        alloc_bytes(131071);
        free_payload(0);
        free_payload(15);
        alloc_bytes(1);
        alloc_bytes(24);
        alloc_bytes(100);
        free_payload(16);
        free_payload(16);
        free_payload(44);
        free_payload(80);
        // Both neighbors are free here, so this one merges on both sides.
        free_payload(40);
        alloc_bytes(65520);
        alloc_bytes(8);
        free_payload(16);
        alloc_bytes(65505);
        free_payload(16);
        alloc_bytes(65488);
        free_payload(16);
        free_payload(65535);
        wait_quiet();
    endtask

    task automatic test_heap_limits();
        logic [LIMIT_W-1:0] lim;
        int unsigned        fill;
        idle_pct  = 13;
        stall_pct = 13;
        for (int k = 0; k < 10; k++) begin
            case (k)
                0: lim = 17'd0;
                1: lim = 17'd1;
                2: lim = 17'd16;
                3: lim = 17'd17;
                4: lim = 17'd48;
                5: lim = 17'd65535;
                6: lim = 17'd65536;
                7: lim = 17'd65537;
                8: lim = 17'd131071;
                default: lim = 17'd4096;
            endcase
            write_heap_limit(lim);
            if (lim == 0 || lim > HEAP) begin
                fill = HEAP - HDR;
            end else begin
                fill = (lim > HDR) ? 32'(lim) - HDR : 0;
            end
            alloc_bytes(fill);
            alloc_bytes(1);
            free_payload(16);
            alloc_bytes(1);
            alloc_bytes(24);
            free_payload(16);
            free_payload(16);
        end
        wait_quiet();
    endtask

    task automatic test_backpressure();
        idle_pct  = 0;
        stall_pct = 0;
        write_heap_limit(17'd2048);
        hold_requests++;
        repeat (24) send_request(next_random_request());
        wait_quiet();
    endtask

    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] lim;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  lim = 17'd0;     end
                1: begin idle_pct = 80; stall_pct = 0;  lim = 17'd4096;  end
                2: begin idle_pct = 0;  stall_pct = 80; lim = 17'd65535; end
                default: begin idle_pct = 13; stall_pct = 13; lim = 17'd1024; end
            endcase
            write_heap_limit(lim);
            repeat (PER_PHASE) send_request(next_random_request());
        end
        wait_quiet();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_edge_requests();
        test_heap_limits();
        test_backpressure();
        test_random_traffic();
        wait_quiet();
        $display("Ran %0d requests: %0d granted, %0d freed, %0d refused.",
                 n_requests, n_granted, n_freed, n_refused);
        $display("Checked %0d replies across %0d heap_limit writes, %0d mismatches.",
                 n_checked, n_limit_writes, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/ffha_dpath.sv
hw/rtl/first_fit_heap_allocator.sv
dv/testbench.sv
